/* src/ufc_pkg.sv */
// Shared types, constants and character classes for the frequency command block.
// No dependencies; compile first.
package ufc_pkg;

  localparam int DIV_W = 32;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [16:0] SAT_LIMIT   = 17'd100000;
  localparam logic [16:0] FREQ_LIMIT  = 17'd50000;
  localparam logic [31:0] PERIOD_MAX  = 32'd65536;
  localparam logic [31:0] CLK_DEFAULT = 32'd84000000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_CHECK,
    ST_DIV1,
    ST_MUL,
    ST_DIV2_START,
    ST_DIV2,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_DIGIT,
    PH_TAIL,
    PH_BAD
  } phase_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_lead_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
  endfunction

  function automatic logic is_tail_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

endpackage

/* src/ufc_if.sv */
// Valid/ready channel interfaces: received characters in, timer settings out.
// Depends on nothing.
interface ufc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ufc_res_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [15:0] prescaler;
  logic [15:0] reload;
  logic [15:0] compare;

  modport source (output valid, output status, output prescaler, output reload,
                  output compare, input ready);
  modport sink   (input valid, input status, input prescaler, input reload,
                  input compare, output ready);
endinterface

/* src/ufc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ufc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 15,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/ufc_div.sv */
// Restoring 32/32 unsigned divider, one quotient bit per cycle.
// Depends on ufc_pkg.
module ufc_div
  import ufc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic             busy;
  logic             done;
  logic [4:0]       cnt;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   diff;
  logic             borrow;

  always_comb begin
    shifted = {rem, quo[DIV_W-1]};
    diff    = shifted - {1'b0, dvs};
    borrow  = diff[DIV_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= borrow ? shifted[DIV_W-1:0] : diff[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], ~borrow};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* src/uart_frequency_command_to_pwm_timing.sv */
// Serial frequency command to half-duty PWM timer settings: top level.
// Depends on ufc_pkg, ufc_if, ufc_ram and ufc_div.
//
// Ordinary characters are taken one per cycle while idle and written into a line
// RAM of LINE_BYTES-1 entries; a character arriving on a full line drops the line.
// A CR or LF on a non-empty line starts processing: each stored character is read
// back from the RAM in a read state and then evaluated in an evaluate state, then two
// divisions (clock / (65537*f) for the prescaler, clock / (f*(prescaler+1)) for the
// period) run one after the other on one shared divider; a line that fails the
// syntax or range check skips both divisions. No input is taken until its result
// has gone into the output register. A finished result waits there while the
// next line is collected. Status 1 means ERR with all timer fields zero.
module uart_frequency_command_to_pwm_timing
  import ufc_pkg::*;
#(
  parameter int LINE_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  ufc_rx_if.sink            rx,
  ufc_res_if.source         res
);

  localparam int DEPTH  = LINE_BYTES - 1;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LEN_W  = $clog2(LINE_BYTES);

  state_t state, state_next;
  phase_t phase;

  logic [31:0]      clk_hz;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] pos;
  logic             digits;
  logic             neg;
  logic [16:0]      value;
  logic             err;
  logic [15:0]      psc;
  logic [31:0]      prod;
  logic [31:0]      span;

  logic             res_valid;
  logic             res_status;
  logic [15:0]      res_psc;
  logic [15:0]      res_arr;
  logic [15:0]      res_cmp;

  logic             rx_fire;
  logic             is_term;
  logic             ram_we;
  logic [7:0]       ch;
  logic [19:0]      acc;
  logic [16:0]      acc_sat;
  logic             parse_ok;
  logic             load_res;
  logic [31:0]      div1_divisor;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  ufc_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_line (
    .clk  (clk),
    .we   (ram_we),
    .waddr(len[ADDR_W-1:0]),
    .wdata(rx.rx_byte),
    .raddr(pos[ADDR_W-1:0]),
    .rdata(ch)
  );

  ufc_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  // value*10 + digit, saturated
  always_comb begin
    acc     = (20'(value) << 3) + (20'(value) << 1) + 20'(ch - CH_ZERO);
    acc_sat = (acc > 20'(SAT_LIMIT)) ? SAT_LIMIT : acc[16:0];
  end

  assign parse_ok = digits && (phase != PH_BAD) && !neg && (value != '0) &&
                    (value < FREQ_LIMIT);
  // 65537*f stays below 2^32 for f < 50000
  assign div1_divisor = {value[15:0], 16'h0000} + 32'(value[15:0]);
  assign load_res = (state == ST_FINISH) && (!res_valid || res.ready);

  always_comb begin
    rx.ready = (state == ST_IDLE);
    rx_fire  = rx.valid && rx.ready;
    is_term  = (rx.rx_byte == CH_CR) || (rx.rx_byte == CH_LF);
    ram_we   = rx_fire && !is_term && (len < LEN_W'(DEPTH));
    div_req.start    = ((state == ST_CHECK) && parse_ok) || (state == ST_DIV2_START);
    div_req.dividend = clk_hz;
    div_req.divisor  = (state == ST_CHECK) ? div1_divisor : prod;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (rx_fire && is_term && (len != '0)) state_next = ST_READ;
      ST_READ:       state_next = (pos == len) ? ST_CHECK : ST_EVAL;
      ST_EVAL:       state_next = ST_READ;
      ST_CHECK:      state_next = parse_ok ? ST_DIV1 : ST_FINISH;
      ST_DIV1:       if (div_rsp.done) state_next = ST_MUL;
      ST_MUL:        state_next = ST_DIV2_START;
      ST_DIV2_START: state_next = ST_DIV2;
      ST_DIV2:       if (div_rsp.done) state_next = ST_FINISH;
      ST_FINISH:     if (load_res) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      len       <= '0;
      clk_hz    <= CLK_DEFAULT;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        clk_hz <= cfg_wdata;
      end
      if (rx_fire && !is_term) begin
        len <= (len < LEN_W'(DEPTH)) ? len + LEN_W'(1) : '0;
      end else if (state == ST_CHECK) begin
        len <= '0;
      end
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // line walk and timer arithmetic
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        pos    <= '0;
        phase  <= PH_LEAD;
        digits <= 1'b0;
        neg    <= 1'b0;
        value  <= '0;
      end
      ST_EVAL: begin
        pos <= pos + LEN_W'(1);
        unique case (phase)
          PH_LEAD: begin
            if (is_lead_space(ch)) begin
              phase <= PH_LEAD;
            end else if ((ch == CH_PLUS) || (ch == CH_MINUS)) begin
              neg   <= (ch == CH_MINUS);
              phase <= PH_DIGIT;
            end else if (is_digit(ch)) begin
              value  <= acc_sat;
              digits <= 1'b1;
              phase  <= PH_DIGIT;
            end else begin
              phase <= PH_BAD;
            end
          end
          PH_DIGIT: begin
            if (is_digit(ch)) begin
              value  <= acc_sat;
              digits <= 1'b1;
            end else if (digits && is_tail_space(ch)) begin
              phase <= PH_TAIL;
            end else begin
              phase <= PH_BAD;
            end
          end
          PH_TAIL:  if (!is_tail_space(ch)) phase <= PH_BAD;
          default:  phase <= PH_BAD;
        endcase
      end
      ST_CHECK: err <= !parse_ok;
      ST_DIV1: begin
        if (div_rsp.done) begin
          psc <= div_rsp.quotient[15:0];
          if (div_rsp.quotient[31:16] != '0) err <= 1'b1;
        end
      end
      ST_MUL: prod <= {16'h0000, value[15:0]} * (32'(psc) + 32'd1);
      ST_DIV2: begin
        if (div_rsp.done) begin
          span <= div_rsp.quotient;
          if ((div_rsp.quotient == '0) || (div_rsp.quotient > PERIOD_MAX)) err <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res_status <= err;
      res_psc    <= err ? '0 : psc;
      res_arr    <= err ? '0 : 16'(span - 32'd1);
      res_cmp    <= err ? '0 : span[16:1];
    end
  end

  assign res.valid     = res_valid;
  assign res.status    = res_status;
  assign res.prescaler = res_psc;
  assign res.reload    = res_arr;
  assign res.compare   = res_cmp;

endmodule

/* src/ufc_checker.sv */
// Port-level checks for the frequency command block, bound to the top level.
// Depends on the top level's ports only.
module ufc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        status,
  input logic [15:0] prescaler,
  input logic [15:0] reload,
  input logic [15:0] compare
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({status, prescaler, reload, compare}))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> (prescaler == 16'd0) && (reload == 16'd0) && (compare == 16'd0))
    else $error("ERR result with nonzero timer fields");

  // half duty: compare is (reload + 1) / 2
  a_half: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> {1'b0, compare} == (({1'b0, reload} + 17'd1) >> 1))
    else $error("compare is not half the period");

  a_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> in_ready && !out_valid)
    else $error("block not idle after reset");

endmodule

bind uart_frequency_command_to_pwm_timing ufc_checker u_ufc_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (rx.ready),
  .out_valid(res.valid),
  .out_ready(res.ready),
  .status   (res.status),
  .prescaler(res.prescaler),
  .reload   (res.reload),
  .compare  (res.compare)
);

/* verif/tb_uart_frequency_command_to_pwm_timing.sv */
// Self-checking bench for the serial frequency command to PWM timing block.
// Depends on ufc_pkg, ufc_if (ufc_rx_if, ufc_res_if) and the block's RTL.
// Characters go in through the rx channel; timer settings are checked against a local predictor.
module tb_uart_frequency_command_to_pwm_timing;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam int unsigned LINE_DEPTH  = 15;
  localparam int unsigned DIGIT_SAT   = 100000;
  localparam int unsigned FREQ_CEIL   = 50000;
  localparam logic [63:0] PERIOD_CAP  = 64'd65536;
  localparam logic [31:0] CLOCK_RESET = 32'd84000000;

  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned SETTLE       = 150;
  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_CHARS  = 162;

  typedef struct packed {
    logic        status;
    logic [15:0] prescaler;
    logic [15:0] reload;
    logic [15:0] compare;
  } timer_setting_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  ufc_rx_if  rx_ch ();
  ufc_res_if res_ch ();

  uart_frequency_command_to_pwm_timing dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rx        (rx_ch),
    .res       (res_ch)
  );

  // predictor state
  logic [7:0]     line_chars [LINE_DEPTH];
  int unsigned    line_len;
  logic [31:0]    clock_hz;
  timer_setting_t expected_settings [$];

  logic [7:0]     rx_pending [$];
  logic [7:0]     lead_blanks [4] = '{CH_SP, CH_TAB, CH_VT, CH_FF};

  int unsigned bytes_queued;
  int unsigned bytes_accepted;
  int unsigned results_ok;
  int unsigned results_err;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned rx_gap;
  int unsigned rx_calm;
  int unsigned res_stall;
  int unsigned res_calm;
  int unsigned hold_left;
  int unsigned hold_requests;
  int unsigned holds_served;
  timer_setting_t want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    if (mismatches < 40) $display("MISMATCH @%0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 160);
  endfunction

  // Timer settings the block should report for the line now stored.
  function automatic timer_setting_t settings_for_line();
    int unsigned pos;
    int unsigned value;
    int unsigned digits;
    bit          negative;
    logic [63:0] clk64;
    logic [63:0] psc;
    logic [63:0] span;
    timer_setting_t r;
    r = '0;
    r.status = STATUS_ERR;
    pos = 0;
    value = 0;
    digits = 0;
    negative = 1'b0;
    while (pos < line_len && (line_chars[pos] inside {CH_SP, CH_TAB, CH_VT, CH_FF})) pos++;
    if (pos < line_len && (line_chars[pos] == CH_PLUS || line_chars[pos] == CH_MINUS)) begin
      negative = (line_chars[pos] == CH_MINUS);
      pos++;
    end
    while (pos < line_len && line_chars[pos] >= CH_0 && line_chars[pos] <= CH_9) begin
      value = value * 10 + int'(line_chars[pos] - CH_0);
      if (value > DIGIT_SAT) value = DIGIT_SAT;
      digits++;
      pos++;
    end
    if (digits == 0) return r;
    while (pos < line_len && (line_chars[pos] inside {CH_SP, CH_TAB})) pos++;
    if (pos != line_len) return r;
    if (negative || value == 0 || value >= FREQ_CEIL) return r;
    clk64 = {32'd0, clock_hz};
    if (clk64 == 0) return r;
    psc = clk64 / (64'd65537 * value);
    if (psc > 64'hFFFF) return r;
    span = clk64 / (value * (psc + 1));
    if (span == 0 || span > PERIOD_CAP) return r;
    r.status    = STATUS_OK;
    r.prescaler = psc[15:0];
    r.reload    = 16'(span - 1);
    r.compare   = 16'(span / 2);
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      rx_ch.valid <= 1'b0;
      rx_gap = 0;
      rx_calm = 0;
    end else begin
      if (rx_ch.valid && rx_ch.ready) begin
        if (rx_ch.rx_byte == CH_CR || rx_ch.rx_byte == CH_LF) begin
          if (line_len != 0) begin
            expected_settings.push_back(settings_for_line());
            line_len = 0;
          end
        end else if (line_len < LINE_DEPTH) begin
          line_chars[line_len] = rx_ch.rx_byte;
          line_len++;
        end else begin
          line_len = 0;  // overflow drops the whole line
        end
        bytes_accepted++;
        if (rx_calm != 0) begin
          rx_calm--;
        end else begin
          rx_gap = draw_gap();
          if ($urandom_range(0, 59) == 0) rx_calm = $urandom_range(20, 150);
        end
      end
      if (!rx_ch.valid || rx_ch.ready) begin
        if (rx_gap != 0) begin
          rx_gap--;
          rx_ch.valid <= 1'b0;
        end else if (rx_pending.size() != 0) begin
          rx_ch.valid   <= 1'b1;
          rx_ch.rx_byte <= rx_pending.pop_front();
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      res_stall = 0;
      res_calm = 0;
      hold_left = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_settings.size() == 0) begin
          flag_mismatch("result with no terminated line pending");
        end else begin
          want = expected_settings.pop_front();
          if (res_ch.status !== want.status)
            flag_mismatch($sformatf("status got %0d want %0d", res_ch.status, want.status));
          if (res_ch.prescaler !== want.prescaler)
            flag_mismatch($sformatf("prescaler got %0d want %0d",
                                    res_ch.prescaler, want.prescaler));
          if (res_ch.reload !== want.reload)
            flag_mismatch($sformatf("reload got %0d want %0d", res_ch.reload, want.reload));
          if (res_ch.compare !== want.compare)
            flag_mismatch($sformatf("compare got %0d want %0d", res_ch.compare, want.compare));
          if (want.status == STATUS_OK) results_ok++;
          else results_err++;
        end
      end
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (res_stall != 0) begin
        res_stall--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if (res_calm != 0) begin
          res_calm--;
        end else if ($urandom_range(0, 3) == 0) begin
          res_stall = draw_gap();
          if ($urandom_range(0, 99) == 0) res_calm = $urandom_range(50, 300);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, expected_settings.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic queue_char(input logic [7:0] c);
    rx_pending.push_back(c);
    bytes_queued++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i]);
  endtask

  task automatic wait_idle();
    while (bytes_accepted != bytes_queued || expected_settings.size() != 0) @(posedge clk);
    // a trailing empty terminator may still be in flight
    repeat (SETTLE) @(posedge clk);
  endtask

  // One setting of the timer clock, then random command lines.
  task automatic run_phase(input logic [31:0] clock_value, input bit squeeze);
    int unsigned start;
    int unsigned kind;
    int unsigned n;
    int unsigned r;
    int unsigned freq;
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= clock_value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    clock_hz = clock_value;
    if (squeeze) hold_requests++;
    start = bytes_queued;
    while (bytes_queued - start < PHASE_CHARS) begin
      kind = $urandom_range(0, 99);
      if (kind < 68) begin
        // well-formed command with random content
        n = $urandom_range(0, 2);
        repeat (n) queue_char(lead_blanks[$urandom_range(0, 3)]);
        r = $urandom_range(0, 19);
        if (r < 3) queue_char(CH_PLUS);
        else if (r == 3) queue_char(CH_MINUS);
        r = $urandom_range(0, 9);
        case (r)
          0: freq = $urandom_range(1, 9);
          1: freq = $urandom_range(49990, 50010);
          2: freq = 0;
          3: freq = $urandom_range(1, 99);
          4: freq = $urandom_range(1, 999);
          default: freq = $urandom_range(1, 49999);
        endcase
        if ($urandom_range(0, 4) == 0) queue_text($sformatf("%07d", freq));
        else queue_text($sformatf("%0d", freq));
        n = $urandom_range(0, 2);
        repeat (n) queue_char($urandom_range(0, 1) ? CH_SP : CH_TAB);
      end else if (kind < 78) begin
        n = $urandom_range(1, 14);
        repeat (n) queue_char(8'($urandom_range(0, 255)));
      end else if (kind < 85) begin
        // around the store depth: the sixteenth character drops the line
        n = $urandom_range(15, 26);
        repeat (n) begin
          if ($urandom_range(0, 7) == 0) queue_char(8'($urandom_range(0, 255)));
          else queue_char(CH_0 + 8'($urandom_range(0, 9)));
        end
      end else if (kind < 91) begin
        // saturating value
        n = $urandom_range(6, 13);
        queue_char(CH_0 + 8'($urandom_range(1, 9)));
        repeat (n - 1) queue_char(CH_0 + 8'($urandom_range(0, 9)));
      end else if (kind < 96) begin
        queue_text($sformatf("%0d", $urandom_range(1, 999)));
        queue_char(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) queue_text($sformatf("%0d", $urandom_range(0, 9)));
      end
      queue_char($urandom_range(0, 1) ? CH_CR : CH_LF);
    end
  endtask

  initial begin
    logic [31:0] phase_clocks [PHASES];
    phase_clocks = '{32'd84000000, 32'd0, 32'd1, 32'd3, 32'd49999, 32'hFFFF_FFFF,
                     32'd3276784463, 32'd0, 32'd1000000, 32'd84000000};
    phase_clocks[7] = $urandom();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    res_ch.ready = 1'b0;
    line_len = 0;
    clock_hz = CLOCK_RESET;
    bytes_queued = 0;
    bytes_accepted = 0;
    results_ok = 0;
    results_err = 0;
    mismatches = 0;
    cycle_count = 0;
    hold_requests = 0;
    holds_served = 0;
    for (int i = 0; i < LINE_DEPTH; i++) line_chars[i] = '0;

    // directed lines at the reset clock
    queue_text("1\r");        // lowest frequency
    queue_text("49999\n");    // highest frequency
    queue_text("\n");         // empty line, no result
    queue_text("-0\r");       // minus zero
    queue_text("50000\r");    // just out of range
    queue_char(CH_NUL);       // NUL in a line
    queue_char(CH_CR);
    queue_text("+9 x\r");     // bad trailing text

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASES; p++) run_phase(phase_clocks[p], p == 0);

    wait_idle();
    if (expected_settings.size() != 0)
      flag_mismatch($sformatf("%0d expected results never came", expected_settings.size()));
    $display("sent %0d characters over %0d clock settings, incl. a %0d-cycle output hold",
             bytes_accepted, PHASES + 1, HOLD_CYCLES);
    $display("checked %0d timer results: %0d OK, %0d ERR, %0d mismatches",
             results_ok + results_err, results_ok, results_err, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
src/ufc_pkg.sv
src/ufc_if.sv
src/ufc_ram.sv
src/ufc_div.sv
src/uart_frequency_command_to_pwm_timing.sv
src/ufc_checker.sv
verif/tb_uart_frequency_command_to_pwm_timing.sv
